FILE: rtl/core/fpa_pkg.sv
// Shared types and constants for the fixed-point ALU core.
// Used by every module under rtl/core; the channel interfaces do not use it.
`default_nettype none

package fpa_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned PROD_W   = 64;
  // quotient bits resolved in each divider stage
  localparam int unsigned DIV_STEP = 4;

  localparam logic [DATA_W-1:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

  typedef enum logic [2:0] {
    KIND_ADD = 3'd0,
    KIND_SUB = 3'd1,
    KIND_MUL = 3'd2,
    KIND_DIV = 3'd3,
    KIND_MIN = 3'd4,
    KIND_MAX = 3'd5,
    KIND_INC = 3'd6,
    KIND_DEC = 3'd7
  } kind_e;

  // fields that ride along the divider pipeline
  typedef struct packed {
    kind_e              kind;
    logic               neg;
    logic               gt;
    logic               lt;
    logic               eq;
    logic [DATA_W-1:0]  simple;
    logic               simple_ovf;
    logic [PROD_W-1:0]  prod;
  } side_t;

endpackage

`default_nettype wire

FILE: rtl/core/fpa_in_if.sv
// Input channel of the fixed-point ALU: opcode and two raw operands.
// Depends on nothing but the handshake convention valid/ready.
`default_nettype none

interface fpa_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, kind, operand_a, operand_b, input ready);
  modport sink   (input valid, kind, operand_a, operand_b, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/fpa_out_if.sv
// Output channel of the fixed-point ALU: raw result and status flags.
// Depends on nothing but the handshake convention valid/ready.
`default_nettype none

interface fpa_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               a_greater;
  logic               a_less;
  logic               a_equal;
  logic               overflowed;
  logic               divide_by_zero;

  modport source (output valid, result_value, a_greater, a_less, a_equal, overflowed,
                  divide_by_zero, input ready);
  modport sink   (input valid, result_value, a_greater, a_less, a_equal, overflowed,
                  divide_by_zero, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/fpa_front.sv
// Front stages: decode, add/sub/inc/dec/min/max, compare, magnitudes,
// then the multiply stage and divider setup. Uses fpa_pkg and fpa_in_if.
`default_nettype none

module fpa_front #(
  parameter int unsigned FRACTION_BITS = 8,
  parameter int unsigned QW            = 40
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         en_i,
  fpa_in_if.sink            in_i,
  output logic              valid_o,
  output fpa_pkg::side_t    side_o,
  output logic [31:0]       rem_o,
  output logic [QW-1:0]     nq_o,
  output logic [31:0]       den_o
);

  logic signed [31:0] a, b;
  fpa_pkg::kind_e     kind;
  logic [32:0]        addend;
  logic               cin;
  logic [32:0]        sum;
  logic               gt, lt, eq;
  logic [31:0]        simple;
  logic               simple_ovf;

  // stage one registers
  logic               valid1_q;
  fpa_pkg::kind_e     kind1_q;
  logic [31:0]        ma1_q, mb1_q;
  logic               neg1_q, gt1_q, lt1_q, eq1_q;
  logic [31:0]        simple1_q;
  logic               sovf1_q;

  // stage two registers
  logic               valid2_q;
  fpa_pkg::side_t     side2_q;
  logic [QW-1:0]      nq2_q;
  logic [31:0]        den2_q;

  assign in_i.ready = en_i;
  assign a    = in_i.operand_a;
  assign b    = in_i.operand_b;
  assign kind = fpa_pkg::kind_e'(in_i.kind);

  // pick the second adder input for add, sub, inc and dec
  always_comb begin
    cin    = 1'b0;
    addend = {b[31], b};
    case (kind)
      fpa_pkg::KIND_SUB: begin
        addend = ~{b[31], b};
        cin    = 1'b1;
      end
      fpa_pkg::KIND_INC: addend = 33'd1;
      fpa_pkg::KIND_DEC: addend = '1;
      default:           addend = {b[31], b};
    endcase
  end

  assign sum = {a[31], a} + addend + {32'd0, cin};
  assign gt  = a > b;
  assign lt  = a < b;
  assign eq  = a == b;

  // saturate the sum, or take min/max
  always_comb begin
    simple_ovf = 1'b0;
    simple     = sum[31:0];
    case (kind)
      fpa_pkg::KIND_MIN: simple = gt ? b : a;
      fpa_pkg::KIND_MAX: simple = lt ? b : a;
      default: begin
        simple_ovf = sum[32] ^ sum[31];
        if (simple_ovf) begin
          simple = sum[32] ? fpa_pkg::SAT_MIN : fpa_pkg::SAT_MAX;
        end
      end
    endcase
  end

  // stage one: decode and magnitudes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind1_q   <= kind;
      ma1_q     <= a[31] ? (~a + 32'd1) : a;
      mb1_q     <= b[31] ? (~b + 32'd1) : b;
      neg1_q    <= a[31] ^ b[31];
      gt1_q     <= gt;
      lt1_q     <= lt;
      eq1_q     <= eq;
      simple1_q <= simple;
      sovf1_q   <= simple_ovf;
    end
  end

  // stage two: multiply and load the divider
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side2_q.kind       <= kind1_q;
      side2_q.neg        <= neg1_q;
      side2_q.gt         <= gt1_q;
      side2_q.lt         <= lt1_q;
      side2_q.eq         <= eq1_q;
      side2_q.simple     <= simple1_q;
      side2_q.simple_ovf <= sovf1_q;
      side2_q.prod       <= 64'(ma1_q) * 64'(mb1_q);
      nq2_q              <= QW'(ma1_q) << FRACTION_BITS;
      den2_q             <= mb1_q;
    end
  end

  assign valid_o = valid2_q;
  assign side_o  = side2_q;
  assign rem_o   = 32'd0;
  assign nq_o    = nq2_q;
  assign den_o   = den2_q;

endmodule

`default_nettype wire

FILE: rtl/core/fpa_div_stage.sv
// One stage of the restoring divider: resolves DIV_STEP quotient bits.
// Uses fpa_pkg; chained by the top level.
`default_nettype none

module fpa_div_stage #(
  parameter int unsigned QW = 40
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  fpa_pkg::side_t      side_i,
  input  wire logic [31:0]    rem_i,
  input  wire logic [QW-1:0]  nq_i,
  input  wire logic [31:0]    den_i,
  output logic                valid_o,
  output fpa_pkg::side_t      side_o,
  output logic [31:0]         rem_o,
  output logic [QW-1:0]       nq_o,
  output logic [31:0]         den_o
);

  logic [31:0]    rem;
  logic [QW-1:0]  nq;
  logic [32:0]    trial;
  logic           valid_q;
  fpa_pkg::side_t side_q;
  logic [31:0]    rem_q;
  logic [QW-1:0]  nq_q;
  logic [31:0]    den_q;

  // shift in numerator bits, subtract where the divisor fits
  always_comb begin
    rem   = rem_i;
    nq    = nq_i;
    trial = '0;
    for (int i = 0; i < int'(fpa_pkg::DIV_STEP); i++) begin
      trial = {rem, nq[QW-1]};
      if (trial >= {1'b0, den_i}) begin
        trial = trial - {1'b0, den_i};
        nq    = {nq[QW-2:0], 1'b1};
      end else begin
        nq    = {nq[QW-2:0], 1'b0};
      end
      rem = trial[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q <= side_i;
      rem_q  <= rem;
      nq_q   <= nq;
      den_q  <= den_i;
    end
  end

  assign valid_o = valid_q;
  assign side_o  = side_q;
  assign rem_o   = rem_q;
  assign nq_o    = nq_q;
  assign den_o   = den_q;

endmodule

`default_nettype wire

FILE: rtl/core/fpa_back.sv
// Back stages: round multiply and divide magnitudes, then sign, saturate
// and select the result. Uses fpa_pkg and fpa_out_if.
`default_nettype none

module fpa_back #(
  parameter int unsigned FRACTION_BITS = 8,
  parameter int unsigned QW            = 40
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           en_i,
  input  wire logic           valid_i,
  input  fpa_pkg::side_t      side_i,
  input  wire logic [31:0]    rem_i,
  input  wire logic [QW-1:0]  nq_i,
  input  wire logic [31:0]    den_i,
  fpa_out_if.source           out_o
);

  localparam logic [63:0] HALF = 64'd1 << (FRACTION_BITS - 1);

  logic [63:0]    prod_rnd;
  logic           round_up;
  logic           valid1_q;
  fpa_pkg::side_t side1_q;
  logic [63:0]    mag1_q;
  logic           dz1_q;

  logic           mag_ovf;
  logic [31:0]    mag_res;
  logic [31:0]    res;
  logic           ovf;

  logic           valid2_q;
  logic [31:0]    res2_q;
  logic           gt2_q, lt2_q, eq2_q, ovf2_q, dz2_q;

  assign prod_rnd = side_i.prod + HALF;
  assign round_up = {rem_i, 1'b0} >= {1'b0, den_i};

  // stage one: rounded magnitude
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;
      dz1_q   <= (side_i.kind == fpa_pkg::KIND_DIV) && (den_i == 32'd0);
      if (side_i.kind == fpa_pkg::KIND_MUL) begin
        mag1_q <= prod_rnd >> FRACTION_BITS;
      end else begin
        mag1_q <= 64'(nq_i) + 64'(round_up);
      end
    end
  end

  // clamp the magnitude with its sign
  always_comb begin
    mag_ovf = side1_q.neg ? (mag1_q > 64'h8000_0000) : (mag1_q > 64'h7fff_ffff);
    mag_res = side1_q.neg ? (~mag1_q[31:0] + 32'd1) : mag1_q[31:0];
    if (mag_ovf) begin
      mag_res = side1_q.neg ? fpa_pkg::SAT_MIN : fpa_pkg::SAT_MAX;
    end
  end

  // select the result for the opcode
  always_comb begin
    res = side1_q.simple;
    ovf = side1_q.simple_ovf;
    case (side1_q.kind)
      fpa_pkg::KIND_MUL: begin
        res = mag_res;
        ovf = mag_ovf;
      end
      fpa_pkg::KIND_DIV: begin
        res = dz1_q ? 32'd0 : mag_res;
        ovf = !dz1_q && mag_ovf;
      end
      default: begin
        res = side1_q.simple;
        ovf = side1_q.simple_ovf;
      end
    endcase
  end

  // stage two: output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res2_q <= res;
      gt2_q  <= side1_q.gt;
      lt2_q  <= side1_q.lt;
      eq2_q  <= side1_q.eq;
      ovf2_q <= ovf;
      dz2_q  <= dz1_q;
    end
  end

  assign out_o.valid          = valid2_q;
  assign out_o.result_value   = res2_q;
  assign out_o.a_greater      = gt2_q;
  assign out_o.a_less         = lt2_q;
  assign out_o.a_equal        = eq2_q;
  assign out_o.overflowed     = ovf2_q;
  assign out_o.divide_by_zero = dz2_q;

endmodule

`default_nettype wire

FILE: rtl/core/fixed_point_alu_core.sv
// Top level of the pipelined fixed-point ALU (Q(32-F).F raw operands).
// Depends on fpa_pkg, fpa_in_if, fpa_out_if, fpa_front, fpa_div_stage, fpa_back.
//
//   channel  dir  interface   payload
//   in_i     in   fpa_in_if   kind, operand_a, operand_b
//   out_o    out  fpa_out_if  result_value, a_greater, a_less, a_equal,
//                             overflowed, divide_by_zero
//
// Accepts one item per cycle while the output is not stalled; the divider
// stages resolve 4 quotient bits each.
// Every opcode takes the same path, so results leave in order.
// A stall at the output freezes the whole pipeline; in_i.ready follows it.
// Reset clears the valid bits only.
`default_nettype none

module fixed_point_alu_core #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fpa_in_if.sink     in_i,
  fpa_out_if.source  out_o
);

  localparam int unsigned STAGES =
    (32 + FRACTION_BITS + fpa_pkg::DIV_STEP - 1) / fpa_pkg::DIV_STEP;
  localparam int unsigned QW = STAGES * fpa_pkg::DIV_STEP;

  logic           en;
  logic           valid_s [STAGES+1];
  fpa_pkg::side_t side_s  [STAGES+1];
  logic [31:0]    rem_s   [STAGES+1];
  logic [QW-1:0]  nq_s    [STAGES+1];
  logic [31:0]    den_s   [STAGES+1];

  // advance whenever the output register is free or being drained
  assign en = !out_o.valid || out_o.ready;

  fpa_front #(
    .FRACTION_BITS (FRACTION_BITS),
    .QW            (QW)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .in_i    (in_i),
    .valid_o (valid_s[0]),
    .side_o  (side_s[0]),
    .rem_o   (rem_s[0]),
    .nq_o    (nq_s[0]),
    .den_o   (den_s[0])
  );

  for (genvar g = 0; g < STAGES; g++) begin : g_div
    fpa_div_stage #(
      .QW (QW)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_s[g]),
      .side_i  (side_s[g]),
      .rem_i   (rem_s[g]),
      .nq_i    (nq_s[g]),
      .den_i   (den_s[g]),
      .valid_o (valid_s[g+1]),
      .side_o  (side_s[g+1]),
      .rem_o   (rem_s[g+1]),
      .nq_o    (nq_s[g+1]),
      .den_o   (den_s[g+1])
    );
  end

  fpa_back #(
    .FRACTION_BITS (FRACTION_BITS),
    .QW            (QW)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_s[STAGES]),
    .side_i  (side_s[STAGES]),
    .rem_i   (rem_s[STAGES]),
    .nq_i    (nq_s[STAGES]),
    .den_i   (den_s[STAGES]),
    .out_o   (out_o)
  );

`ifndef SYNTHESIS
  // exactly one comparison flag per item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> $onehot({out_o.a_greater, out_o.a_less, out_o.a_equal}))
    else $error("comparison flags not one-hot");

  // zero divisor gives zero and no overflow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.divide_by_zero |->
      out_o.result_value == 32'sd0 && !out_o.overflowed)
    else $error("divide by zero result wrong");

  // saturated result sits on a bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.overflowed |->
      (out_o.result_value == fpa_pkg::SAT_MAX) || (out_o.result_value == fpa_pkg::SAT_MIN))
    else $error("overflow without saturation");

  // input is taken exactly when the pipeline moves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == (!out_o.valid || out_o.ready))
    else $error("input ready out of step with pipeline");

  // a stalled output keeps its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.result_value))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

FILE: tb/fpa_result_checker.sv
// Checker for the fixed-point ALU core: watches both channels, predicts each result.
// Depends on fpa_pkg, fpa_in_if and fpa_out_if.
`default_nettype none

module fpa_result_checker #(
  parameter int unsigned FRACTION_BITS = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fpa_in_if         in_i,
  fpa_out_if        out_o,
  output int        fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] value;
    logic               gt;
    logic               lt;
    logic               eq;
    logic               ovf;
    logic               dz;
  } alu_result_t;

  alu_result_t pending_results[$];

  // Saturate a wide signed value to 32 bits.
  function automatic logic signed [31:0] saturate(input logic signed [65:0] v,
                                                  inout logic ovf);
    if (v > 66'sd2147483647) begin
      ovf = 1'b1;
      return fpa_pkg::SAT_MAX;
    end
    if (v < -66'sd2147483648) begin
      ovf = 1'b1;
      return fpa_pkg::SAT_MIN;
    end
    return v[31:0];
  endfunction

  // Compute the exact result of one operation.
  function automatic alu_result_t alu_predict(input logic [2:0] op,
                                              input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    alu_result_t res;
    logic signed [65:0] wa, wb, sv;
    logic [65:0] ma, mb, q, num, rmd;
    logic neg, ovf;
    wa  = a;
    wb  = b;
    ma  = (wa < 0) ? -wa : wa;
    mb  = (wb < 0) ? -wb : wb;
    neg = (a < 0) != (b < 0);
    ovf = 1'b0;
    res = '0;
    case (fpa_pkg::kind_e'(op))
      fpa_pkg::KIND_ADD: res.value = saturate(wa + wb, ovf);
      fpa_pkg::KIND_SUB: res.value = saturate(wa - wb, ovf);
      fpa_pkg::KIND_MUL: begin
        q  = ((ma * mb) + (66'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
        sv = neg ? -$signed(q) : $signed(q);
        res.value = saturate(sv, ovf);
      end
      fpa_pkg::KIND_DIV: begin
        if (b == 0) begin
          res.dz = 1'b1;
          res.value = '0;
        end else begin
          num = ma << FRACTION_BITS;
          q   = num / mb;
          rmd = num % mb;
          if (rmd * 2 >= mb) q = q + 1;
          sv = neg ? -$signed(q) : $signed(q);
          res.value = saturate(sv, ovf);
        end
      end
      fpa_pkg::KIND_MIN: res.value = (a > b) ? b : a;
      fpa_pkg::KIND_MAX: res.value = (a < b) ? b : a;
      fpa_pkg::KIND_INC: res.value = saturate(wa + 1, ovf);
      default:           res.value = saturate(wa - 1, ovf);
    endcase
    res.ovf = ovf;
    res.gt  = a > b;
    res.lt  = a < b;
    res.eq  = a == b;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  // Queue predictions on input items, compare on output items.
  always @(posedge clk_i) begin
    alu_result_t want;
    if (rst_ni) begin
      if (out_o.valid && out_o.ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected item", out_o.result_value, '0);
        end else begin
          want = pending_results.pop_front();
          if (out_o.result_value !== want.value)
            report_mismatch("result_value", out_o.result_value, want.value);
          if (out_o.a_greater !== want.gt)
            report_mismatch("a_greater", 32'(out_o.a_greater), 32'(want.gt));
          if (out_o.a_less !== want.lt)
            report_mismatch("a_less", 32'(out_o.a_less), 32'(want.lt));
          if (out_o.a_equal !== want.eq)
            report_mismatch("a_equal", 32'(out_o.a_equal), 32'(want.eq));
          if (out_o.overflowed !== want.ovf)
            report_mismatch("overflowed", 32'(out_o.overflowed), 32'(want.ovf));
          if (out_o.divide_by_zero !== want.dz)
            report_mismatch("divide_by_zero", 32'(out_o.divide_by_zero), 32'(want.dz));
        end
      end
      if (in_i.valid && in_i.ready)
        pending_results.push_back(alu_predict(in_i.kind, in_i.operand_a, in_i.operand_b));
    end
  end

  function automatic int outstanding();
    return pending_results.size();
  endfunction

  // Report anything left over at the end.
  task automatic check_drained();
    if (pending_results.size() != 0)
      report_mismatch("missing items", 32'(pending_results.size()), 32'd0);
  endtask

endmodule

`default_nettype wire

FILE: tb/fixed_point_alu_core_test.sv
// Top of the fixed-point ALU core testbench: clock, reset, stimulus and verdict.
// Depends on fpa_pkg, the channel interfaces, fixed_point_alu_core and fpa_result_checker.
`default_nettype none

module fixed_point_alu_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRACTION_BITS = 8;
  localparam int RANDOM_ITEMS = 1930;
  localparam int LATENCY = 4 + (32 + FRACTION_BITS + 3) / 4;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  bit   calm_phase;
  bit   hold_sink;

  fpa_in_if  in_ch();
  fpa_out_if out_ch();

  fixed_point_alu_core #(.FRACTION_BITS(FRACTION_BITS)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  fpa_result_checker #(.FRACTION_BITS(FRACTION_BITS)) checker_inst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Pick a random operand, biased toward edge values.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      3: return $urandom_range(0, 1) ? 32'h0000_0100 : 32'hffff_ff00;
      4: return $signed($urandom_range(0, 8191)) - 4096;
      5: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $urandom();
    endcase
  endfunction

  // Offer one item and hold it until accepted, with random gaps before it.
  task automatic send_item(input fpa_pkg::kind_e op, input logic [31:0] a,
                           input logic [31:0] b);
    if (!calm_phase && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic pause_sender();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Receiver: random stall bursts, a long hold-off on request, none late in the run.
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_sink = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    logic [31:0] edge_vals[6];
    int wait_cycles;
    edge_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1, 32'h100};
    calm_phase      = 1'b0;
    hold_sink       = 1'b0;
    rst_ni          = 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.kind      <= '0;
    in_ch.operand_a <= '0;
    in_ch.operand_b <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed: every opcode on extremes, zero divisor, ties, equal operands.
    for (int k = 0; k < 8; k++) begin
      send_item(fpa_pkg::kind_e'(k), edge_vals[k % 6], edge_vals[(k + 1) % 6]);
      send_item(fpa_pkg::kind_e'(k), edge_vals[(k + 2) % 6], edge_vals[(k + 2) % 6]);
    end
    send_item(fpa_pkg::KIND_DIV, 32'h0000_0500, 32'h0);
    send_item(fpa_pkg::KIND_DIV, 32'h8000_0000, 32'h0000_0001);
    send_item(fpa_pkg::KIND_MUL, 32'h0000_0180, 32'h0000_0001);
    send_item(fpa_pkg::KIND_MUL, 32'hffff_fe80, 32'h0000_0001);
    send_item(fpa_pkg::KIND_DIV, 32'h0000_0001, 32'h0000_0200);
    send_item(fpa_pkg::KIND_DIV, 32'hffff_ffff, 32'h0000_0200);
    send_item(fpa_pkg::KIND_INC, 32'h7fff_ffff, 32'h8000_0000);
    send_item(fpa_pkg::KIND_DEC, 32'h8000_0000, 32'h7fff_ffff);
    send_item(fpa_pkg::KIND_MUL, 32'h8000_0000, 32'h8000_0000);

    // Sender pauses until every expected result has arrived.
    pause_sender();
    while (checker_inst.outstanding() != 0) @(posedge clk_i);

    // Receiver holds off while the sender keeps offering.
    hold_sink = 1'b1;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - 300) calm_phase = 1'b1;
      send_item(fpa_pkg::kind_e'($urandom_range(0, 7)), pick_operand(), pick_operand());
    end
    pause_sender();

    wait_cycles = 0;
    while (checker_inst.outstanding() != 0 && wait_cycles < 10000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (LATENCY + 4) @(posedge clk_i);
    checker_inst.check_drained();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
